[design/assert_macros.svh]
// Assertion macros shared by the packet gate RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PLG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("packet gate: invariant violated");
// Check that a condition in one cycle leads to a consequence in the next.
`define PLG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packet gate: next-cycle check failed");
`else
`define PLG_ASSERT(lbl, clk, rst_n, prop)
`define PLG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/plg_pkg.sv]
// Types, codes and constants of the packet gate.
package plg_pkg;

  localparam logic [15:0] BUF_SIZE  = 16'd512;
  localparam logic [15:0] HDR_BYTES = 16'd3;
  localparam logic [15:0] TYPE_BYTES = 16'd1;
  localparam logic [15:0] BODY_MAX  = BUF_SIZE - HDR_BYTES;

  // command selector
  localparam logic [1:0] CMD_TX   = 2'd0;
  localparam logic [1:0] CMD_RX   = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // link mode
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_SEND = 2'd2;

  // result status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REPEAT  = 3'd1;
  localparam logic [2:0] ST_INVAL   = 3'd2;
  localparam logic [2:0] ST_PERM    = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;
  localparam logic [2:0] ST_BIG     = 3'd5;
  localparam logic [2:0] ST_OVERRUN = 3'd6;
  localparam logic [2:0] ST_NOMEM   = 3'd7;

  // configuration register indexes
  localparam int unsigned   CFG_IDX_W = 1;
  localparam logic [0:0]    CFG_MASK  = 1'b0;
  localparam logic [0:0]    CFG_VALUE = 1'b1;
  localparam logic [7:0]    TAG_RESET = 8'd96;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] chunk_len;
    logic [7:0]  head_tag;
    logic [15:0] head_len;
    logic [15:0] rx_capacity;
    logic [15:0] rx_len;
  } plg_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] count;
    logic        packet_done;
  } plg_out_t;

  typedef struct packed {
    logic [1:0]  link_mode;
    logic [15:0] tx_total;
    logic [15:0] tx_offset;
    logic [7:0]  tx_tag_held;
    logic [15:0] rx_stored_len;
  } plg_state_t;

  typedef struct packed {
    logic [7:0] status_tag_mask;
    logic [7:0] status_tag_value;
  } plg_cfg_t;

endpackage

[design/plg_core.sv]
// Single-pass checks of one request against the link state.
module plg_core (
  input  plg_pkg::plg_in_t    req,
  input  plg_pkg::plg_state_t st,
  input  plg_pkg::plg_cfg_t   cfg,
  output plg_pkg::plg_out_t   res,
  output plg_pkg::plg_state_t st_nxt
);
  import plg_pkg::*;

  logic        start;
  logic [15:0] tot_new;
  logic [15:0] eff_total;
  logic [15:0] eff_off;
  logic [7:0]  eff_tag;
  logic [16:0] end_sum;
  logic        cap_low;

  function automatic logic is_status(input logic [7:0] tag, input plg_cfg_t c);
    is_status = ((tag & c.status_tag_mask) == c.status_tag_value);
  endfunction

  assign start     = (st.tx_total == '0);
  assign tot_new   = req.head_len + HDR_BYTES;
  assign eff_total = start ? tot_new : st.tx_total;
  assign eff_off   = start ? '0 : st.tx_offset;
  assign eff_tag   = start ? req.head_tag : st.tx_tag_held;
  assign end_sum   = {1'b0, eff_off} + {1'b0, req.chunk_len};
  assign cap_low   = (req.rx_capacity < BUF_SIZE);

  always_comb begin
    res    = '0;
    st_nxt = st;
    case (req.cmd)
      CMD_TX: begin
        if (req.chunk_len == '0) begin
          res.status = ST_INVAL;
        end else if (st.link_mode == MODE_WAIT) begin
          if (start && is_status(req.head_tag, cfg)) begin
            res.status = ST_REPEAT;
            res.count  = req.chunk_len;
          end else begin
            res.status = ST_PERM;
          end
        end else if (start && (req.chunk_len < HDR_BYTES)) begin
          res.status = ST_SHORT;
        end else if (start && (tot_new > BUF_SIZE)) begin
          res.status       = ST_BIG;
          st_nxt.tx_total  = '0;
        end else if (end_sum > {1'b0, eff_total}) begin
          // a total opened by this chunk stays open
          res.status = ST_OVERRUN;
          if (start) begin
            st_nxt.tx_total    = tot_new;
            st_nxt.tx_tag_held = req.head_tag;
            st_nxt.tx_offset   = '0;
          end
        end else begin
          res.count        = req.chunk_len;
          st_nxt.tx_offset = end_sum[15:0];
          if (end_sum[15:0] == eff_total) begin
            res.packet_done    = 1'b1;
            st_nxt.tx_total    = '0;
            st_nxt.tx_tag_held = '0;
            if (is_status(eff_tag, cfg)) begin
              st_nxt.link_mode = MODE_WAIT;
            end
          end else begin
            st_nxt.tx_total    = eff_total;
            st_nxt.tx_tag_held = eff_tag;
          end
        end
      end
      CMD_RX: begin
        if (cap_low) begin
          res.status = ST_INVAL;
        end else if (st.link_mode != MODE_WAIT) begin
          res.status = ST_PERM;
        end else if (req.rx_len > BODY_MAX) begin
          res.status           = ST_NOMEM;
          st_nxt.rx_stored_len = req.rx_len;
        end else begin
          st_nxt.rx_stored_len = req.rx_len + HDR_BYTES;
          st_nxt.link_mode     = MODE_SEND;
          st_nxt.tx_total      = '0;
          res.count            = req.rx_len + HDR_BYTES + TYPE_BYTES;
        end
      end
      CMD_READ: begin
        if (cap_low) begin
          res.status = ST_INVAL;
        end else begin
          res.count = st.rx_stored_len;
        end
      end
      default: begin
        res.status = ST_INVAL;
      end
    endcase
  end

endmodule

[design/proxy_link_packet_gate.sv]
// Top level of the tagged packet link gate: request/result registers and link state.
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_stall     in_data   (plg_in_t)
//  out_     output     out_valid / out_stall   out_data  (plg_out_t)
//  cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per cycle while in_stall is low. A request is held in the input
// register until the result register is free or drains, passes the header, size
// and offset checks in a single pass, and lands in the result register, which
// raises out_valid. Reset puts the link in send mode with all counters zero and
// the status tag mask and value at 96. in_stall is high only when both registers
// hold a request and the result side stalls; cfg_ready is always high.
`include "assert_macros.svh"

module proxy_link_packet_gate (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  plg_pkg::plg_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output plg_pkg::plg_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [plg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import plg_pkg::*;

  logic       in_vld_r;
  plg_in_t    in_r;
  logic       out_vld_r;
  plg_out_t   out_r;
  plg_state_t st_r;
  plg_state_t st_nxt;
  plg_cfg_t   cfg_r;
  plg_out_t   res;
  logic       adv;
  logic       res_err;

  // Advance the held request whenever the result register is free or drains now.
  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && out_vld_r && out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Held result that reports an error rather than a length.
  assign res_err   = out_vld_r && (out_r.status != ST_OK) && (out_r.status != ST_REPEAT);

  plg_core u_core (
    .req    (in_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // Input register: take a new request, or drop the old one once it advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Result register: load on advance, clear valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  // Link state commits only when the request it belongs to advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.link_mode     <= MODE_SEND;
      st_r.tx_total      <= '0;
      st_r.tx_offset     <= '0;
      st_r.tx_tag_held   <= '0;
      st_r.rx_stored_len <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Configuration writes; indexes outside the list fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.status_tag_mask  <= TAG_RESET;
      cfg_r.status_tag_value <= TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASK:  cfg_r.status_tag_mask  <= cfg_data;
        CFG_VALUE: cfg_r.status_tag_value <= cfg_data;
        default:   cfg_r <= cfg_r;
      endcase
    end
  end

  `PLG_ASSERT(a_done_ok, clk, rst_n, out_vld_r && out_r.packet_done |-> out_r.status == ST_OK)
  `PLG_ASSERT(a_err_zero, clk, rst_n, res_err |-> out_r.count == '0)
  `PLG_ASSERT(a_total_max, clk, rst_n, st_r.tx_total <= BUF_SIZE)
  `PLG_ASSERT(a_off_below, clk, rst_n, st_r.tx_total != '0 |-> st_r.tx_offset < st_r.tx_total)
  `PLG_ASSERT(a_wait_closed, clk, rst_n, st_r.link_mode == MODE_WAIT |-> st_r.tx_total == '0)
  `PLG_ASSERT_NXT(a_adv_loads, clk, rst_n, adv, out_vld_r)

endmodule
